// ===== hw/rtl/pngse_pkg.sv =====
// Shared types and constants of the stored-image PNG encoder.
`default_nettype none
package pngse_pkg;

  localparam int DimW = 15;
  localparam logic [DimW-1:0] DimReset = 15'd1;
  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [16:0] AdlerMod = 17'd65521;
  localparam logic [15:0] ZlibHdr = 16'(((32'h0800 + 32'd30) / 32'd31) * 32'd31);

  localparam logic CmdStart = 1'b0;
  localparam logic CmdPixel = 1'b1;

  localparam logic CfgWidth = 1'b0;
  localparam logic CfgHeight = 1'b1;

  // Kind of byte sequence that one queue entry expands into.
  typedef enum logic [1:0] {
    JOB_HEADER = 2'd0,
    JOB_PIXEL  = 2'd1
  } job_kind_t;

  // One classified item between the front and the back part.
  typedef struct packed {
    job_kind_t       kind;
    logic            row_start;   // emit the stored block header first
    logic            last_row;    // final flag of the stored block
    logic            image_end;   // emit the trailer afterwards
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    logic [7:0]      b0;
    logic [7:0]      b1;
    logic [7:0]      b2;
  } job_t;

  // One step of the byte-wise reflected CRC-32, with the model's inverted form.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = ~crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return ~c;
  endfunction

  // Adds a byte or a sum below the modulus and reduces once.
  function automatic logic [15:0] mod_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= AdlerMod) begin
      s = s - AdlerMod;
    end
    return s[15:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/pngse_front.sv =====
// Front part: accepts commands, tracks rows and columns, queues jobs.
`default_nettype none
module pngse_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  valid,
  output logic                       ready,
  input  wire logic                  cmd,
  input  wire logic [7:0]            pixel_byte0,
  input  wire logic [7:0]            pixel_byte1,
  input  wire logic [7:0]            pixel_byte2,
  input  wire logic [pngse_pkg::DimW-1:0] width,
  input  wire logic [pngse_pkg::DimW-1:0] height,
  output pngse_pkg::job_t            job,
  output logic                       job_push,
  input  wire logic                  job_full
);
  import pngse_pkg::*;

  logic [DimW-1:0] column_count;
  logic [DimW-1:0] row_count;
  logic            image_open;
  logic [DimW-1:0] col_inc;
  logic [DimW-1:0] row_inc;
  logic            row_done;
  logic            img_done;
  logic            fire;

  assign ready = !job_full;
  assign fire = valid && ready;
  assign col_inc = column_count + 1'b1;
  assign row_inc = row_count + 1'b1;
  assign row_done = ({1'b0, col_inc} >= {1'b0, width}) || (col_inc == '0);
  assign img_done = row_done && (({1'b0, row_inc} >= {1'b0, height}) || (row_inc == '0));

  always_comb begin
    job.kind = (cmd == CmdStart) ? JOB_HEADER : JOB_PIXEL;
    job.row_start = (column_count == '0);
    job.last_row = ({1'b0, row_inc} >= {1'b0, height});
    job.image_end = img_done;
    job.width = width;
    job.height = height;
    job.b0 = pixel_byte0;
    job.b1 = pixel_byte1;
    job.b2 = pixel_byte2;
    job_push = fire && ((cmd == CmdStart) || image_open);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count <= '0;
      image_open <= 1'b0;
    end else if (fire) begin
      if (cmd == CmdStart) begin
        column_count <= '0;
        row_count <= '0;
        image_open <= 1'b1;
      end else if (image_open) begin
        if (row_done) begin
          column_count <= '0;
          if (img_done) begin
            row_count <= '0;
            image_open <= 1'b0;
          end else begin
            row_count <= row_inc;
          end
        end else begin
          column_count <= col_inc;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pngse_queue.sv =====
// Short job queue between the front and the back part.
`default_nettype none
module pngse_queue #(
  parameter int Depth = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  pngse_pkg::job_t      push_job,
  output logic                 full,
  input  wire logic            pop,
  output pngse_pkg::job_t      head,
  output logic                 not_empty
);
  import pngse_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  job_t            mem [Depth];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;

  assign full = (count == (AW + 1)'(Depth));
  assign not_empty = (count != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW + 1)'(push) - (AW + 1)'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pngse_back.sv =====
// Back part: expands jobs into file bytes and keeps the CRC and Adler sums.
`default_nettype none
module pngse_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  pngse_pkg::job_t  job,
  input  wire logic        job_valid,
  output logic             job_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             last_of_run,
  output logic             image_done
);
  import pngse_pkg::*;

  // Byte selection per step. Header: 43 bytes. Pixel: optional 6 byte
  // block header (steps 0..5), three pixel bytes (6..8), optional 20 byte
  // trailer (9..28).
  logic [5:0]  step;
  logic [5:0]  step_next;
  logic [5:0]  first_step;
  logic [5:0]  cur;
  logic [7:0]  byte_val;
  logic        covered;
  logic        crc_clear;
  logic        adler_on;
  logic        is_last;
  logic [31:0] chunk_crc;
  logic [15:0] adler_low_sum;
  logic [15:0] adler_high_sum;
  logic [15:0] low_next;
  logic [31:0] w32;
  logic [31:0] h32;
  logic [31:0] row_bytes;
  logic [31:0] idat_len;
  logic [15:0] len16;
  logic [31:0] adler32;
  logic        busy;
  logic        take;
  logic        out_free;

  assign w32 = (job.width == '0) ? 32'd1 : {17'd0, job.width};
  assign h32 = (job.height == '0) ? 32'd1 : {17'd0, job.height};
  assign row_bytes = w32 * 32'd3 + 32'd1;
  assign idat_len = h32 * (row_bytes + 32'd5) + 32'd6;
  assign len16 = row_bytes[15:0];
  assign adler32 = {adler_high_sum, adler_low_sum};

  assign first_step = (job.kind == JOB_PIXEL && !job.row_start) ? 6'd6 : 6'd0;
  assign cur = busy ? step : first_step;
  assign out_free = !out_valid || out_ready;
  assign take = job_valid && out_free;

  always_comb begin
    byte_val = 8'd0;
    covered = 1'b0;
    crc_clear = 1'b0;
    adler_on = 1'b0;
    is_last = 1'b0;
    if (job.kind == JOB_HEADER) begin
      unique case (cur)
        6'd0: byte_val = 8'd137;
        6'd1: byte_val = 8'd80;
        6'd2: byte_val = 8'd78;
        6'd3: byte_val = 8'd71;
        6'd4: byte_val = 8'd13;
        6'd5: byte_val = 8'd10;
        6'd6: byte_val = 8'd26;
        6'd7: byte_val = 8'd10;
        6'd8, 6'd9, 6'd10: byte_val = 8'd0;
        6'd11: byte_val = 8'd13;
        6'd12: begin byte_val = "I"; covered = 1'b1; crc_clear = 1'b1; end
        6'd13: begin byte_val = "H"; covered = 1'b1; end
        6'd14: begin byte_val = "D"; covered = 1'b1; end
        6'd15: begin byte_val = "R"; covered = 1'b1; end
        6'd16: begin byte_val = w32[31:24]; covered = 1'b1; end
        6'd17: begin byte_val = w32[23:16]; covered = 1'b1; end
        6'd18: begin byte_val = w32[15:8]; covered = 1'b1; end
        6'd19: begin byte_val = w32[7:0]; covered = 1'b1; end
        6'd20: begin byte_val = h32[31:24]; covered = 1'b1; end
        6'd21: begin byte_val = h32[23:16]; covered = 1'b1; end
        6'd22: begin byte_val = h32[15:8]; covered = 1'b1; end
        6'd23: begin byte_val = h32[7:0]; covered = 1'b1; end
        6'd24: begin byte_val = 8'd8; covered = 1'b1; end
        6'd25: begin byte_val = 8'd2; covered = 1'b1; end
        6'd26, 6'd27, 6'd28: covered = 1'b1;
        6'd29: byte_val = chunk_crc[31:24];
        6'd30: byte_val = chunk_crc[23:16];
        6'd31: byte_val = chunk_crc[15:8];
        6'd32: byte_val = chunk_crc[7:0];
        6'd33: byte_val = idat_len[31:24];
        6'd34: byte_val = idat_len[23:16];
        6'd35: byte_val = idat_len[15:8];
        6'd36: byte_val = idat_len[7:0];
        6'd37: begin byte_val = "I"; covered = 1'b1; crc_clear = 1'b1; end
        6'd38: begin byte_val = "D"; covered = 1'b1; end
        6'd39: begin byte_val = "A"; covered = 1'b1; end
        6'd40: begin byte_val = "T"; covered = 1'b1; end
        6'd41: begin byte_val = ZlibHdr[15:8]; covered = 1'b1; end
        6'd42: begin byte_val = ZlibHdr[7:0]; covered = 1'b1; is_last = 1'b1; end
        default: byte_val = 8'd0;
      endcase
    end else begin
      unique case (cur)
        6'd0: begin byte_val = {7'd0, job.last_row}; covered = 1'b1; end
        6'd1: begin byte_val = len16[7:0]; covered = 1'b1; end
        6'd2: begin byte_val = len16[15:8]; covered = 1'b1; end
        6'd3: begin byte_val = ~len16[7:0]; covered = 1'b1; end
        6'd4: begin byte_val = ~len16[15:8]; covered = 1'b1; end
        6'd5: begin byte_val = 8'd0; covered = 1'b1; adler_on = 1'b1; end
        6'd6: begin byte_val = job.b2; covered = 1'b1; adler_on = 1'b1; end
        6'd7: begin byte_val = job.b1; covered = 1'b1; adler_on = 1'b1; end
        6'd8: begin
          byte_val = job.b0; covered = 1'b1; adler_on = 1'b1;
          is_last = !job.image_end;
        end
        6'd9: begin byte_val = adler32[31:24]; covered = 1'b1; end
        6'd10: begin byte_val = adler32[23:16]; covered = 1'b1; end
        6'd11: begin byte_val = adler32[15:8]; covered = 1'b1; end
        6'd12: begin byte_val = adler32[7:0]; covered = 1'b1; end
        6'd13: byte_val = chunk_crc[31:24];
        6'd14: byte_val = chunk_crc[23:16];
        6'd15: byte_val = chunk_crc[15:8];
        6'd16: byte_val = chunk_crc[7:0];
        6'd17, 6'd18, 6'd19, 6'd20: byte_val = 8'd0;
        6'd21: begin byte_val = "I"; covered = 1'b1; crc_clear = 1'b1; end
        6'd22: begin byte_val = "E"; covered = 1'b1; end
        6'd23: begin byte_val = "N"; covered = 1'b1; end
        6'd24: begin byte_val = "D"; covered = 1'b1; end
        6'd25: byte_val = chunk_crc[31:24];
        6'd26: byte_val = chunk_crc[23:16];
        6'd27: byte_val = chunk_crc[15:8];
        6'd28: begin byte_val = chunk_crc[7:0]; is_last = 1'b1; end
        default: byte_val = 8'd0;
      endcase
    end
    step_next = cur + 1'b1;
  end

  assign job_pop = take && is_last;
  assign low_next = mod_add(adler_low_sum, {8'd0, byte_val});

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte <= byte_val;
      last_of_run <= is_last;
      image_done <= is_last && (job.kind == JOB_PIXEL) && job.image_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      out_valid <= 1'b0;
      chunk_crc <= '0;
      adler_low_sum <= 16'd1;
      adler_high_sum <= '0;
    end else begin
      if (out_free) begin
        out_valid <= take;
      end
      if (take) begin
        busy <= !is_last;
        step <= step_next;
        if (covered) begin
          chunk_crc <= crc_byte(crc_clear ? 32'd0 : chunk_crc, byte_val);
        end
        if (job.kind == JOB_HEADER) begin
          adler_low_sum <= 16'd1;
          adler_high_sum <= '0;
        end else if (adler_on) begin
          adler_low_sum <= low_next;
          adler_high_sum <= mod_add(adler_high_sum, low_next);
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/png_stored_image_encoder.sv =====
// Top level of the stored-image PNG encoder: registers, front, queue and back part.
// Path: an item's bytes pass the job queue and then the back part's output register.
// Throughput: one byte per cycle unless out_ready stalls, set by the back part's sequencer;
// a pixel gives 3 bytes, 9 when it opens a row, up to 29 with the trailer; a start gives 43.
// Reset: synchronous, active high; clears the queue, counters, sums and the output stage,
// and sets both image dimensions to 1.
`default_nettype none
module png_stored_image_encoder #(
  parameter int QueueDepth = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        cmd,
  input  wire logic [7:0]  pixel_byte0,
  input  wire logic [7:0]  pixel_byte1,
  input  wire logic [7:0]  pixel_byte2,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [pngse_pkg::DimW-1:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             last_of_run,
  output logic             image_done
);
  import pngse_pkg::*;

  logic [DimW-1:0] image_width;
  logic [DimW-1:0] image_height;
  job_t            front_job;
  job_t            head_job;
  logic            job_push;
  logic            job_full;
  logic            job_pop;
  logic            job_valid;

  // Configuration is always taken; user must write it only while the block is idle; unenforced.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= DimReset;
      image_height <= DimReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CfgWidth:  image_width <= cfg_data;
        CfgHeight: image_height <= cfg_data;
        default:   image_width <= image_width;
      endcase
    end
  end

  // The front part classifies each beat and drops pixels with no image open.
  pngse_front u_front (
    .clk(clk), .rst(rst),
    .valid(in_valid), .ready(in_ready),
    .cmd(cmd), .pixel_byte0(pixel_byte0), .pixel_byte1(pixel_byte1),
    .pixel_byte2(pixel_byte2),
    .width(image_width), .height(image_height),
    .job(front_job), .job_push(job_push), .job_full(job_full)
  );

  pngse_queue #(.Depth(QueueDepth)) u_queue (
    .clk(clk), .rst(rst),
    .push(job_push), .push_job(front_job), .full(job_full),
    .pop(job_pop), .head(head_job), .not_empty(job_valid)
  );

  // The back part emits one byte per cycle into a single output register while out_ready allows.
  pngse_back u_back (
    .clk(clk), .rst(rst),
    .job(head_job), .job_valid(job_valid), .job_pop(job_pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_byte(out_byte), .last_of_run(last_of_run), .image_done(image_done)
  );

endmodule
`default_nettype wire

// ===== bench/png_stored_image_encoder_tb.sv =====
// Self-checking testbench of the stored-image PNG encoder with a built-in byte predictor.
`timescale 1ns / 100ps
`default_nettype none
module png_stored_image_encoder_tb;
  import pngse_pkg::*;

  // A pending beat: either a pixel/start item or a register write.
  typedef struct {
    logic              is_cfg;
    logic              cmd;
    logic [7:0]        b0;
    logic [7:0]        b1;
    logic [7:0]        b2;
    logic              idx;
    logic [DimW-1:0]   data;
  } beat_t;

  // One expected output byte with its markers.
  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       file_end;
  } png_byte_t;

  localparam int WatchdogLimit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic cmd = CmdStart;
  logic [7:0] pixel_byte0 = '0;
  logic [7:0] pixel_byte1 = '0;
  logic [7:0] pixel_byte2 = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CfgWidth;
  logic [DimW-1:0] cfg_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_byte;
  logic last_of_run;
  logic image_done;

  png_stored_image_encoder u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
    .pixel_byte0(pixel_byte0), .pixel_byte1(pixel_byte1), .pixel_byte2(pixel_byte2),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .last_of_run(last_of_run), .image_done(image_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: a private copy of the encoder's registers and running sums.
  logic [DimW-1:0] pred_width, pred_height;
  logic [31:0]     pred_crc;
  logic [15:0]     pred_adler_lo, pred_adler_hi;
  logic [DimW-1:0] pred_col, pred_row;
  logic            pred_open;

  beat_t     pending_beats[$];
  png_byte_t expected_bytes[$];
  int        run_bytes;
  int        mismatches = 0;
  bit        stim_done = 1'b0;
  bit        timed_out = 1'b0;
  int        idle_cycles = 0;

  // Bitwise reflected CRC-32 update, finished (inverted) form kept in the state.
  function automatic logic [31:0] crc_next(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = ~crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    return ~c;
  endfunction

  task automatic push_byte(logic [7:0] b, bit covered);
    png_byte_t e;
    if (covered) pred_crc = crc_next(pred_crc, b);
    e.data = b;
    e.run_end = 1'b0;
    e.file_end = 1'b0;
    expected_bytes.push_back(e);
    run_bytes++;
  endtask

  task automatic push_word(logic [31:0] v, bit covered);
    for (int i = 3; i >= 0; i--) push_byte(v[8*i +: 8], covered);
  endtask

  task automatic start_chunk(logic [31:0] len, string name);
    push_word(len, 1'b0);
    pred_crc = '0;
    for (int i = 0; i < 4; i++) push_byte(name[i], 1'b1);
  endtask

  task automatic adler_add(logic [7:0] b);
    int unsigned s1, s2;
    s1 = (pred_adler_lo + b) % 65521;
    s2 = (pred_adler_hi + s1) % 65521;
    pred_adler_lo = s1[15:0];
    pred_adler_hi = s2[15:0];
  endtask

  // Expands one accepted item into the PNG bytes it must produce.
  task automatic predict_png_bytes(beat_t it);
    int unsigned w, h, row_bytes;
    logic [15:0] len, nlen;
    png_byte_t e;
    w = (pred_width == 0) ? 1 : pred_width;
    h = (pred_height == 0) ? 1 : pred_height;
    row_bytes = w * 3 + 1;
    run_bytes = 0;
    if (it.cmd == CmdStart) begin
      pred_crc = '0;
      pred_adler_lo = 16'd1;
      pred_adler_hi = '0;
      pred_col = '0;
      pred_row = '0;
      pred_open = 1'b1;
      push_byte(8'd137, 0); push_byte(8'd80, 0); push_byte(8'd78, 0); push_byte(8'd71, 0);
      push_byte(8'd13, 0);  push_byte(8'd10, 0); push_byte(8'd26, 0); push_byte(8'd10, 0);
      start_chunk(32'd13, "IHDR");
      push_word(w, 1'b1);
      push_word(h, 1'b1);
      push_byte(8'd8, 1); push_byte(8'd2, 1);
      push_byte(8'd0, 1); push_byte(8'd0, 1); push_byte(8'd0, 1);
      push_word(pred_crc, 1'b0);
      start_chunk(h * (row_bytes + 5) + 6, "IDAT");
      push_byte(8'h08, 1'b1);
      push_byte(8'h1D, 1'b1);
    end else if (pred_open) begin
      if (pred_col == 0) begin
        len = row_bytes[15:0];
        nlen = ~len;
        push_byte((pred_row + 1 >= h) ? 8'd1 : 8'd0, 1'b1);
        push_byte(len[7:0], 1); push_byte(len[15:8], 1);
        push_byte(nlen[7:0], 1); push_byte(nlen[15:8], 1);
        adler_add(8'd0);
        push_byte(8'd0, 1'b1);
      end
      adler_add(it.b2); push_byte(it.b2, 1'b1);
      adler_add(it.b1); push_byte(it.b1, 1'b1);
      adler_add(it.b0); push_byte(it.b0, 1'b1);
      pred_col = pred_col + 1'b1;
      if (pred_col >= w || pred_col == 0) begin
        pred_col = '0;
        pred_row = pred_row + 1'b1;
        if (pred_row >= h || pred_row == 0) begin
          push_word({pred_adler_hi, pred_adler_lo}, 1'b1);
          push_word(pred_crc, 1'b0);
          start_chunk(32'd0, "IEND");
          push_word(pred_crc, 1'b0);
          e = expected_bytes.pop_back();
          e.file_end = 1'b1;
          expected_bytes.push_back(e);
          pred_open = 1'b0;
          pred_row = '0;
        end
      end
    end
    if (run_bytes > 0) begin
      e = expected_bytes.pop_back();
      e.run_end = 1'b1;
      expected_bytes.push_back(e);
    end
  endtask

  // Random gap length: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Driver: presents queued beats on the item or the register channel and holds
  // them until accepted. Gaps are inserted between beats.
  int in_gap = 0;
  always @(posedge clk) begin
    beat_t nx;
    if (rst) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        nx.is_cfg = 1'b0;
        nx.cmd = cmd;
        nx.b0 = pixel_byte0;
        nx.b1 = pixel_byte1;
        nx.b2 = pixel_byte2;
        predict_png_bytes(nx);
        void'(pending_beats.pop_front());
        in_gap = gap_len();
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CfgWidth) pred_width = cfg_data;
        else pred_height = cfg_data;
        void'(pending_beats.pop_front());
        in_gap = gap_len();
      end
      if ((in_valid && !in_ready) || (cfg_valid && !cfg_ready)) begin
        // Hold the current beat unchanged.
      end else if (in_gap > 0 || pending_beats.size() == 0 ||
                   (pending_beats[0].is_cfg && pending_beats[0].cmd)) begin
        if (in_gap > 0) in_gap = in_gap - 1;
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
      end else begin
        nx = pending_beats[0];
        in_valid <= !nx.is_cfg;
        cfg_valid <= nx.is_cfg;
        cmd <= nx.cmd;
        pixel_byte0 <= nx.b0;
        pixel_byte1 <= nx.b1;
        pixel_byte2 <= nx.b2;
        cfg_index <= nx.idx;
        cfg_data <= nx.data;
      end
    end
  end

  // Monitor: compares each output beat against the oldest expected byte and
  // stalls the output side at random.
  int out_gap = 0;
  always @(posedge clk) begin
    png_byte_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected beat: byte %02h last_of_run %b image_done %b",
                     out_byte, last_of_run, image_done);
        end else begin
          e = expected_bytes.pop_front();
          if (out_byte !== e.data || last_of_run !== e.run_end ||
              image_done !== e.file_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected %02h/%b/%b, got %02h/%b/%b", e.data,
                       e.run_end, e.file_end, out_byte, last_of_run, image_done);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (out_ready && $urandom_range(0, 3) == 0) begin
        out_gap <= gap_len();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: counts cycles in which no beat is accepted on any channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (cfg_valid && cfg_ready) ||
        (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) timed_out <= 1'b1;
    end
  end

  task automatic add_item(logic c, logic [7:0] p0, logic [7:0] p1, logic [7:0] p2);
    beat_t b;
    b = '{1'b0, c, p0, p1, p2, CfgWidth, '0};
    pending_beats.push_back(b);
  endtask

  task automatic add_rand_pixel();
    add_item(CmdPixel, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // A register write must wait until the encoder is idle, so the stimulus
  // blocks until all earlier beats are out, then lets the pipeline drain.
  task automatic write_reg(logic idx, logic [DimW-1:0] val);
    beat_t b;
    wait (pending_beats.size() == 0 && expected_bytes.size() == 0);
    repeat (60) @(posedge clk);
    b = '{1'b1, 1'b0, '0, '0, '0, idx, val};
    pending_beats.push_back(b);
    wait (pending_beats.size() == 0);
  endtask

  task automatic set_size(int w, int h);
    write_reg(CfgWidth, w[DimW-1:0]);
    write_reg(CfgHeight, h[DimW-1:0]);
  endtask

  // Full image of random pixels at the current size.
  task automatic add_image(int w, int h);
    add_item(CmdStart, 8'($urandom), 8'($urandom), 8'($urandom));
    for (int i = 0; i < w * h; i++) add_rand_pixel();
  endtask

  initial begin
    int w, h, sent;
    pred_width = DimReset;
    pred_height = DimReset;
    pred_crc = '0;
    pred_adler_lo = 16'd1;
    pred_adler_hi = '0;
    pred_col = '0;
    pred_row = '0;
    pred_open = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: a pixel with no image open, reset sizes, byte extremes.
    add_item(CmdPixel, 8'hFF, 8'h00, 8'hAA);
    add_item(CmdStart, 8'h00, 8'h00, 8'h00);
    add_item(CmdPixel, 8'h00, 8'hFF, 8'h55);
    add_item(CmdPixel, 8'hFF, 8'hFF, 8'hFF);
    // Zero registers act as one.
    set_size(0, 0);
    add_item(CmdStart, 8'hFF, 8'hFF, 8'hFF);
    add_item(CmdPixel, 8'hFF, 8'hFF, 8'hFF);
    // Start during an open image abandons it.
    set_size(3, 2);
    add_item(CmdStart, 8'h00, 8'h00, 8'h00);
    add_item(CmdPixel, 8'h12, 8'h34, 8'h56);
    add_item(CmdPixel, 8'h00, 8'h00, 8'h00);
    add_image(3, 2);
    // Widest row with a 16-bit block length, tallest image; abandoned after two pixels.
    set_size(21844, 32767);
    add_item(CmdStart, 8'h00, 8'h00, 8'h00);
    add_rand_pixel();
    add_rand_pixel();
    // Width above the range: stored-block length wraps to 16 bits.
    set_size(32767, 1);
    add_item(CmdStart, 8'h00, 8'h00, 8'h00);
    add_rand_pixel();

    // Random part: mostly complete small images, plus stray pixels and restarts.
    sent = 0;
    while (sent < 200) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 4);
      h = $urandom_range(1, 4);
      set_size(w, h);
      if ($urandom_range(0, 4) == 0) begin
        add_rand_pixel();
        add_item(CmdStart, 8'($urandom), 8'($urandom), 8'($urandom));
        for (int i = $urandom_range(0, 3); i > 0; i--) add_rand_pixel();
        sent += 3;
      end
      if (w == 0) w = 1;
      add_image(w, h);
      sent += w * h + 1;
    end
    wait (pending_beats.size() == 0);
    stim_done = 1'b1;
  end

  // End of run: wait for all bytes, let the pipeline settle, then report.
  initial begin
    wait (timed_out || (stim_done && expected_bytes.size() == 0));
    if (!timed_out) repeat (60) @(posedge clk);
    if (timed_out) begin
      $display("CHECK FAILED");
    end else if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
